[hdl/rau_pkg.sv]
// ---------------------------------------------------------------------------
// rau_pkg: shared constants for the rational arithmetic unit
// operation codes, status codes and field widths
// ---------------------------------------------------------------------------
package rau_pkg;
  localparam int FIELD_W = 32;

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_CMP = 3'd4;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_OVF  = 2'd2;

  typedef logic [FIELD_W-1:0] field_t;
endpackage

[hdl/rational_arithmetic_unit.sv]
// ---------------------------------------------------------------------------
// rational_arithmetic_unit: gcd-reduced fraction add, sub, mul, div, compare
// sequence: compare and unused kinds run the serial multiply, the compare, then the result;
// arithmetic runs 32 serial multiply steps, combine, a 64-bit binary gcd
// at one step a cycle, then 64 + 64 restoring divide steps
// throughput: one transaction in flight; next input taken once the result was accepted
// reset: synchronous active-low rst_n returns control to idle, output empty
// ---------------------------------------------------------------------------
module rational_arithmetic_unit #(
  parameter int WORD_BITS = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          in_kind,
  input  logic signed [31:0]  in_a_num,
  input  logic signed [31:0]  in_a_den,
  input  logic signed [31:0]  in_b_num,
  input  logic signed [31:0]  in_b_den,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  out_res_num,
  output logic signed [31:0]  out_res_den,
  output logic signed [1:0]   out_order,
  output logic                out_same_fields,
  output logic [1:0]          out_status
);
  import rau_pkg::*;

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL   = 4'd1;
  localparam logic [3:0] S_MUL2  = 4'd2;
  localparam logic [3:0] S_COMB  = 4'd3;
  localparam logic [3:0] S_GCD   = 4'd4;
  localparam logic [3:0] S_GFIX  = 4'd5;
  localparam logic [3:0] S_DIVN  = 4'd6;
  localparam logic [3:0] S_DIVD  = 4'd7;
  localparam logic [3:0] S_CHECK = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  localparam int MW = 64;  // magnitude width of products and sums
  localparam logic [MW-1:0] LIM = 64'd1 << (WORD_BITS - 1);

  logic [3:0] state_r, state_nxt;
  logic [2:0] kind_r;
  // operand magnitudes and signs
  logic [31:0] x0_r, y0_r, x1_r, y1_r;   // products x0*y0 and x1*y1
  logic        s0_r, s1_r;               // product signs
  logic [31:0] dx_r, dy_r;               // denominator product operands
  logic        sd_r;
  logic signed [31:0] an_r, ad_r, bn_r, bd_r;
  // serial multiply accumulators (shift-and-add, one bit per cycle)
  logic [MW-1:0] p0_r, p1_r, pd_r;
  logic [5:0]    cnt_r;
  logic [6:0]    dcnt_r;
  // combined numerator, denominator
  logic [MW-1:0] nm_r, dm_r;
  logic          nneg_r, dneg_r;
  // gcd working registers
  logic [MW-1:0] ga_r, gb_r;
  logic [6:0]    gsh_r;
  // divider
  logic [MW-1:0] quo_r, rem_r, g_r;
  logic [MW:0]   rtry;
  logic          cmp_lt_r, cmp_gt_r;
  // output register
  logic          ov_r;
  logic signed [31:0] on_r, od_r;
  logic signed [1:0]  oo_r;
  logic          osf_r;
  logic [1:0]    ost_r;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? 32'(-v) : v;
  endfunction

  assign in_stall = (state_r != S_IDLE);
  assign rtry = {rem_r, quo_r[MW-1]} - {1'b0, g_r};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (in_valid) state_nxt = S_MUL;
      S_MUL:   if (cnt_r == 6'd31) state_nxt = S_MUL2;
      S_MUL2:  state_nxt = (kind_r == KIND_CMP || kind_r > KIND_CMP) ? S_CHECK : S_COMB;
      S_COMB:  state_nxt = S_GCD;
      S_GCD:   if (ga_r == '0 || gb_r == '0) state_nxt = S_GFIX;
      S_GFIX:  state_nxt = S_DIVN;
      S_DIVN:  if (dcnt_r == 7'd63) state_nxt = S_DIVD;
      S_DIVD:  if (dcnt_r == 7'd63) state_nxt = S_CHECK;
      S_CHECK: state_nxt = S_OUT;
      S_OUT:   if (!ov_r) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CHECK) ov_r <= 1'b1;
      else if (ov_r && !out_stall) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        kind_r <= in_kind;
        an_r <= in_a_num; ad_r <= in_a_den; bn_r <= in_b_num; bd_r <= in_b_den;
        cnt_r <= '0;
        p0_r <= '0; p1_r <= '0; pd_r <= '0;
        // pick operands: compare and add/sub/div share an*bd
        x0_r <= mag32(in_a_num);
        if (in_kind == KIND_MUL) begin
          y0_r <= mag32(in_b_num); s0_r <= in_a_num[31] ^ in_b_num[31];
          dx_r <= mag32(in_a_den); dy_r <= mag32(in_b_den);
          sd_r <= in_a_den[31] ^ in_b_den[31];
        end else if (in_kind == KIND_DIV) begin
          y0_r <= mag32(in_b_den); s0_r <= in_a_num[31] ^ in_b_den[31];
          dx_r <= mag32(in_a_den); dy_r <= mag32(in_b_num);
          sd_r <= in_a_den[31] ^ in_b_num[31];
        end else begin
          y0_r <= mag32(in_b_den); s0_r <= in_a_num[31] ^ in_b_den[31];
          dx_r <= mag32(in_a_den); dy_r <= mag32(in_b_den);
          sd_r <= in_a_den[31] ^ in_b_den[31];
        end
        x1_r <= mag32(in_b_num); y1_r <= mag32(in_a_den);
        s1_r <= in_b_num[31] ^ in_a_den[31] ^ (in_kind == KIND_SUB);
      end
      S_MUL: begin
        // one multiplier bit per cycle, msb first
        p0_r <= (p0_r << 1) + (y0_r[31] ? {32'd0, x0_r} : '0);
        p1_r <= (p1_r << 1) + (y1_r[31] ? {32'd0, x1_r} : '0);
        pd_r <= (pd_r << 1) + (dy_r[31] ? {32'd0, dx_r} : '0);
        y0_r <= y0_r << 1; y1_r <= y1_r << 1; dy_r <= dy_r << 1;
        cnt_r <= cnt_r + 6'd1;
      end
      S_MUL2: begin
        // signed compare of the two cross products
        cmp_lt_r <= ((s0_r && p0_r != '0) && !(s1_r ^ (kind_r == KIND_SUB) && p1_r != '0))
                 || (!(s0_r && p0_r != '0) && !(s1_r ^ (kind_r == KIND_SUB) && p1_r != '0)
                     && p0_r < p1_r)
                 || ((s0_r && p0_r != '0) && (s1_r ^ (kind_r == KIND_SUB) && p1_r != '0)
                     && p0_r > p1_r);
        cmp_gt_r <= !((s0_r && p0_r != '0) == (s1_r ^ (kind_r == KIND_SUB) && p1_r != '0)
                      && p0_r == p1_r);
      end
      S_COMB: begin
        dm_r <= pd_r;
        dneg_r <= sd_r && pd_r != '0;
        if (kind_r == KIND_MUL || kind_r == KIND_DIV) begin
          nm_r <= p0_r; nneg_r <= s0_r && p0_r != '0;
          ga_r <= p0_r;
        end else if ((s0_r && p0_r != '0) == (s1_r && p1_r != '0)) begin
          nm_r <= p0_r + p1_r; nneg_r <= s0_r && p0_r != '0;
          ga_r <= p0_r + p1_r;
        end else if (p0_r >= p1_r) begin
          nm_r <= p0_r - p1_r; nneg_r <= s0_r && p0_r != p1_r;
          ga_r <= p0_r - p1_r;
        end else begin
          nm_r <= p1_r - p0_r; nneg_r <= s1_r;
          ga_r <= p1_r - p0_r;
        end
        gb_r <= pd_r;
        gsh_r <= '0;
      end
      S_GCD: begin
        // binary gcd, one step per cycle
        if (ga_r != '0 && gb_r != '0) begin
          if (!ga_r[0] && !gb_r[0]) begin
            ga_r <= ga_r >> 1; gb_r <= gb_r >> 1; gsh_r <= gsh_r + 7'd1;
          end else if (!ga_r[0]) ga_r <= ga_r >> 1;
          else if (!gb_r[0]) gb_r <= gb_r >> 1;
          else if (ga_r >= gb_r) ga_r <= (ga_r - gb_r) >> 1;
          else gb_r <= (gb_r - ga_r) >> 1;
        end
      end
      S_GFIX: begin
        g_r <= (ga_r | gb_r) << gsh_r[5:0];
        quo_r <= nm_r; rem_r <= '0; dcnt_r <= '0;
      end
      S_DIVN, S_DIVD: begin
        // restoring division, one quotient bit per cycle
        dcnt_r <= (dcnt_r == 7'd63) ? 7'd0 : dcnt_r + 7'd1;
        if (state_r == S_DIVN && dcnt_r == 7'd63) begin
          // numerator quotient done, start on the denominator
          nm_r <= (!rtry[MW]) ? {quo_r[MW-2:0], 1'b1} : {quo_r[MW-2:0], 1'b0};
          quo_r <= dm_r; rem_r <= '0;
        end else begin
          if (!rtry[MW]) begin
            rem_r <= rtry[MW-1:0];
            quo_r <= {quo_r[MW-2:0], 1'b1};
          end else begin
            rem_r <= {rem_r[MW-2:0], quo_r[MW-1]};
            quo_r <= {quo_r[MW-2:0], 1'b0};
          end
          if (state_r == S_DIVD && dcnt_r == 7'd63)
            dm_r <= (!rtry[MW]) ? {quo_r[MW-2:0], 1'b1} : {quo_r[MW-2:0], 1'b0};
        end
      end
      S_CHECK: begin
        on_r <= '0; od_r <= '0; oo_r <= '0; osf_r <= 1'b0; ost_r <= ST_OK;
        if (kind_r == KIND_CMP) begin
          oo_r  <= cmp_lt_r ? -2'sd1 : (cmp_gt_r ? 2'sd1 : 2'sd0);
          osf_r <= (an_r == bn_r) && (ad_r == bd_r);
        end else if (kind_r < KIND_CMP) begin
          if (pd_r == '0) ost_r <= ST_ZDEN;
          else if ((nneg_r ? nm_r > LIM : nm_r >= LIM) || (dneg_r ? dm_r > LIM : dm_r >= LIM))
            ost_r <= ST_OVF;
          else begin
            on_r <= nneg_r ? 32'(-nm_r) : nm_r[31:0];
            od_r <= dneg_r ? 32'(-dm_r) : dm_r[31:0];
          end
        end
      end
      default: ;
    endcase
  end

  assign out_valid       = ov_r;
  assign out_res_num     = on_r;
  assign out_res_den     = od_r;
  assign out_order       = oo_r;
  assign out_same_fields = osf_r;
  assign out_status      = ost_r;
endmodule

[dv/tb.sv]
// ---------------------------------------------------------------------------
// tb: self-checking bench for the rational arithmetic unit
// random and directed fraction transactions through a valid/stall driver,
// predicted results compared field by field in arrival order
// ---------------------------------------------------------------------------
module tb;
  import rau_pkg::*;

  // one input transaction
  typedef struct packed {
    logic [2:0]         kind;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;
  } frac_op_t;

  // one result transaction
  typedef struct packed {
    logic signed [31:0] res_num;
    logic signed [31:0] res_den;
    logic signed [1:0]  order;
    logic               same_fields;
    logic [1:0]         status;
  } frac_res_t;

  localparam int N_RANDOM  = 750;
  localparam int CYCLE_CAP = 2000000;

  logic clk;
  logic rst_n;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_kind = '0;
  logic signed [31:0] in_a_num = '0, in_a_den = '0, in_b_num = '0, in_b_den = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_res_num, out_res_den;
  logic signed [1:0] out_order;
  logic out_same_fields;
  logic [1:0] out_status;
  // stall as seen at the last rising edge, so the driver knows what was taken
  logic in_stall_q;

  frac_op_t  pending_ops[$];
  frac_res_t expected_res[$];
  int n_errors = 0;
  int n_checked = 0;
  int n_cycles = 0;
  int send_idle_pct;
  int recv_stall_pct;

  rational_arithmetic_unit u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_kind(in_kind),
    .in_a_num(in_a_num), .in_a_den(in_a_den),
    .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_res_num(out_res_num), .out_res_den(out_res_den),
    .out_order(out_order), .out_same_fields(out_same_fields),
    .out_status(out_status)
  );

  // clock: 2 high, 2 low
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // signed magnitude helpers at 64 bits plus a sign
  function automatic logic [63:0] mag_of(logic signed [31:0] v);
    logic signed [63:0] w;
    w = v;
    return (w < 0) ? -w : w;
  endfunction

  function automatic logic [63:0] gcd_of(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // a reduced part fits the signed 32-bit range
  function automatic bit part_fits(bit neg, logic [63:0] m);
    return neg ? (m <= 64'h8000_0000) : (m < 64'h8000_0000);
  endfunction

  // predicted result of one fraction operation
  function automatic frac_res_t fraction_result(frac_op_t op);
    frac_res_t r;
    logic signed [63:0] lhs, rhs;
    logic [63:0] pm, qm, nm, dm, g;
    bit pn, qn, nn, dn;
    r = '0;
    if (op.kind == KIND_CMP) begin
      lhs = 64'(op.a_num) * 64'(op.b_den);
      rhs = 64'(op.b_num) * 64'(op.a_den);
      r.order = (lhs < rhs) ? -2'sd1 : ((lhs > rhs) ? 2'sd1 : 2'sd0);
      r.same_fields = (op.a_num == op.b_num) && (op.a_den == op.b_den);
      return r;
    end
    if (op.kind > KIND_CMP) return r;
    // denominator is a_den*b_den except for divide
    if (op.kind == KIND_DIV) begin
      nm = mag_of(op.a_num) * mag_of(op.b_den);
      nn = (op.a_num[31] != op.b_den[31]) && nm != 0;
      dm = mag_of(op.a_den) * mag_of(op.b_num);
      dn = (op.a_den[31] != op.b_num[31]) && dm != 0;
    end else begin
      dm = mag_of(op.a_den) * mag_of(op.b_den);
      dn = (op.a_den[31] != op.b_den[31]) && dm != 0;
      if (op.kind == KIND_MUL) begin
        nm = mag_of(op.a_num) * mag_of(op.b_num);
        nn = (op.a_num[31] != op.b_num[31]) && nm != 0;
      end else begin
        pm = mag_of(op.a_num) * mag_of(op.b_den);
        pn = (op.a_num[31] != op.b_den[31]) && pm != 0;
        qm = mag_of(op.b_num) * mag_of(op.a_den);
        qn = (op.b_num[31] != op.a_den[31]) && qm != 0;
        if (op.kind == KIND_SUB && qm != 0) qn = !qn;
        if (pn == qn) begin
          nn = pn;
          nm = pm + qm;
        end else if (pm >= qm) begin
          nn = pn;
          nm = pm - qm;
        end else begin
          nn = qn;
          nm = qm - pm;
        end
        if (nm == 0) nn = 0;
      end
    end
    if (dm == 0) begin
      r.status = ST_ZDEN;
      return r;
    end
    g = gcd_of(nm, dm);
    nm = nm / g;
    dm = dm / g;
    if (!part_fits(nn, nm) || !part_fits(dn, dm)) begin
      r.status = ST_OVF;
      return r;
    end
    r.res_num = nn ? -nm[31:0] : nm[31:0];
    r.res_den = dn ? -dm[31:0] : dm[31:0];
    r.status  = ST_OK;
    return r;
  endfunction

  // operand values biased toward edges and small numbers
  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 32'sd0;
      3, 4: return $signed($urandom_range(0, 40)) - 20;
      5, 6: return $signed($urandom_range(0, 2000)) - 1000;
      default: return $urandom;
    endcase
  endfunction

  task automatic queue_op(logic [2:0] k, logic signed [31:0] an, logic signed [31:0] ad,
                          logic signed [31:0] bn, logic signed [31:0] bd);
    frac_op_t op;
    op.kind = k;
    op.a_num = an;
    op.a_den = ad;
    op.b_num = bn;
    op.b_den = bd;
    pending_ops.push_back(op);
  endtask

  // driver: presents queued transactions, changes on the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      // a new transaction goes out once the current one was taken
      if (!in_valid || !in_stall_q) begin
        if (pending_ops.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          {in_kind, in_a_num, in_a_den, in_b_num, in_b_den} <= pending_ops.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  always @(posedge clk) in_stall_q <= in_stall;

  // monitor: accepted inputs produce predictions, accepted outputs are checked
  always @(posedge clk) begin
    frac_res_t got, want;
    if (rst_n) begin
      n_cycles <= n_cycles + 1;
      if (in_valid && !in_stall)
        expected_res.push_back(fraction_result({in_kind, in_a_num, in_a_den,
                                                in_b_num, in_b_den}));
      if (out_valid && !out_stall) begin
        got = {out_res_num, out_res_den, out_order, out_same_fields, out_status};
        if (expected_res.size() == 0) begin
          n_errors <= n_errors + 1;
          if (n_errors < 10) $display("unexpected result transaction %h", got);
        end else begin
          want = expected_res.pop_front();
          n_checked <= n_checked + 1;
          if (got !== want) begin
            n_errors <= n_errors + 1;
            if (n_errors < 10)
              $display("mismatch: num %0d/%0d den %0d/%0d ord %0d/%0d same %0d/%0d st %0d/%0d",
                       want.res_num, got.res_num, want.res_den, got.res_den,
                       want.order, got.order, want.same_fields, got.same_fields,
                       want.status, got.status);
          end
        end
      end
      if (n_cycles > CYCLE_CAP) begin
        $display("timeout after %0d cycles", n_cycles);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int k;
    int phase;
    rst_n = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: every kind, zero denominators, overflow, zero numerators, edges
    queue_op(KIND_ADD, 1, 2, 1, 3);
    queue_op(KIND_SUB, 1, 2, 1, 2);
    queue_op(KIND_SUB, 0, -5, 0, 7);
    queue_op(KIND_MUL, 2, -3, 3, 4);
    queue_op(KIND_DIV, 1, 2, 0, 5);
    queue_op(KIND_ADD, 1, 0, 1, 3);
    queue_op(KIND_MUL, 32'sh8000_0000, 1, 32'sh8000_0000, 1);
    queue_op(KIND_MUL, 32'sh8000_0000, 1, 1, 1);
    queue_op(KIND_MUL, 32'sh8000_0000, 1, -1, 1);
    queue_op(KIND_ADD, 32'sh7fff_ffff, 1, 32'sh7fff_ffff, 1);
    queue_op(KIND_DIV, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff);
    queue_op(KIND_SUB, 32'sh8000_0000, 32'sh8000_0000, 32'sh7fff_ffff, -1);
    queue_op(KIND_CMP, 1, 2, 2, 4);
    queue_op(KIND_CMP, 1, 2, 1, 2);
    queue_op(KIND_CMP, -1, 3, 1, 3);
    queue_op(KIND_CMP, 32'sh8000_0000, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh8000_0000);
    queue_op(3'd5, 1, 2, 3, 4);
    queue_op(3'd6, -1, -1, -1, -1);
    queue_op(3'd7, 32'sh8000_0000, 0, 0, 32'sh8000_0000);
    queue_op(KIND_DIV, -6, 4, 9, -2);
    queue_op(KIND_ADD, 0, -1, 0, 1);

    // random, in four idling phases
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 27; recv_stall_pct = 27; end
      endcase
      for (k = 0; k < N_RANDOM / 4; k++)
        queue_op(($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                             : 3'($urandom_range(0, 4)),
                 pick_value(), pick_value(), pick_value(), pick_value());
      while (pending_ops.size() > 0 || in_valid || expected_res.size() > 0)
        @(posedge clk);
    end
    repeat (400) @(posedge clk);

    $display("checked %0d result transactions over all kinds and four idling phases",
             n_checked);
    if (n_errors == 0 && expected_res.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("%0d mismatches, %0d results outstanding", n_errors, expected_res.size());
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
